### src/platform_interrupt_controller_macros.svh
// Assertion macros used by the interrupt controller checker in pic_monitor.
// Depends on nothing; callers provide clk and arst_n in scope.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_MACROS_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interrupt controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interrupt controller check failed");

`endif

### src/pic_pkg.sv
// Shared types and constants for the platform interrupt controller.
// Depends on nothing; used by the controller, datapath and top level.
package pic_pkg;

	localparam int SRC_W        = 5;
	localparam int PRIO_W       = 3;
	localparam int PRIO_SLOTS   = 16;
	localparam int PRIO_TABLE_W = 48;
	localparam int ENABLE_W     = 16;
	localparam int CFG_DATA_W   = 48;
	localparam int CFG_IDX_W    = 2;
	localparam int REQ_W        = 2;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic [REQ_W-1:0] REQ_RAISE    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLAIM    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_COMPLETE = 2'd2;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} status_t;

endpackage

### src/pic_ctrl.sv
// Sequencing state machine for the platform interrupt controller.
// Depends on pic_pkg; drives the datapath through cmd_t and reads status_t.
module pic_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output pic_pkg::cmd_t    cmd,
	input  pic_pkg::status_t status
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

### src/pic_datapath.sv
// Registers, pending and in-service state, serial source scan and result register.
// Depends on pic_pkg; commanded by pic_ctrl.
module pic_datapath #(
	parameter int NUM_SOURCES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pic_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pic_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [pic_pkg::REQ_W-1:0]       in_type,
	input  logic [pic_pkg::SRC_W-1:0]       in_sid,
	input  pic_pkg::cmd_t                   cmd,
	output pic_pkg::status_t                status,
	output logic [pic_pkg::SRC_W-1:0]       claimed_id,
	output logic                            irq_line,
	output logic                            complete_ignored
);

	localparam int EN_N = (NUM_SOURCES < pic_pkg::ENABLE_W) ? NUM_SOURCES : pic_pkg::ENABLE_W;

	logic [pic_pkg::PRIO_TABLE_W-1:0] prio_table_q;
	logic [pic_pkg::ENABLE_W-1:0]     enable_q;
	logic [pic_pkg::PRIO_W-1:0]       thresh_q;
	logic [NUM_SOURCES-1:0]           pend_q;
	logic [NUM_SOURCES-1:0]           insvc_q;
	logic [NUM_SOURCES-1:0]           pend_d;
	logic [NUM_SOURCES-1:0]           insvc_d;

	logic [pic_pkg::REQ_W-1:0]        type_q;
	logic                             ignored_q;
	logic [pic_pkg::SRC_W-1:0]        pos_q;
	logic [pic_pkg::SRC_W-1:0]        best_id_q;
	logic [pic_pkg::PRIO_W-1:0]       best_prio_q;
	logic                             have_one_q;
	logic                             have_two_q;

	logic [pic_pkg::PRIO_W-1:0]       cur_prio;
	logic                             cur_en;
	logic                             cur_pend;
	logic                             cur_elig;
	logic                             comp_hit;

	always_comb begin
		cur_prio = '0;
		cur_en   = 1'b0;
		cur_pend = 1'b0;
		for (int k = 0; k < pic_pkg::PRIO_SLOTS; k++) begin
			if (pos_q == pic_pkg::SRC_W'(k)) begin
				cur_prio = prio_table_q[pic_pkg::PRIO_W*k +: pic_pkg::PRIO_W];
			end
		end
		for (int k = 0; k < pic_pkg::ENABLE_W; k++) begin
			if (pos_q == pic_pkg::SRC_W'(k)) begin
				cur_en = enable_q[k];
			end
		end
		for (int k = 0; k < NUM_SOURCES; k++) begin
			if (pos_q == pic_pkg::SRC_W'(k)) begin
				cur_pend = pend_q[k];
			end
		end
		cur_elig = cur_pend && cur_en && (cur_prio > thresh_q);
	end

	always_comb begin
		pend_d   = pend_q;
		insvc_d  = insvc_q;
		comp_hit = 1'b0;
		if (cmd.accept) begin
			if (in_type == pic_pkg::REQ_RAISE) begin
				for (int k = 0; k < NUM_SOURCES; k++) begin
					if (in_sid == pic_pkg::SRC_W'(k + 1) && !insvc_q[k]) begin
						pend_d[k] = 1'b1;
					end
				end
			end
			if (in_type == pic_pkg::REQ_COMPLETE) begin
				for (int k = 0; k < EN_N; k++) begin
					if (in_sid == pic_pkg::SRC_W'(k + 1) && enable_q[k]) begin
						insvc_d[k] = 1'b0;
						comp_hit   = 1'b1;
					end
				end
			end
		end
		if (cmd.load && type_q == pic_pkg::REQ_CLAIM) begin
			for (int k = 0; k < NUM_SOURCES; k++) begin
				if (best_id_q == pic_pkg::SRC_W'(k + 1)) begin
					pend_d[k]  = 1'b0;
					insvc_d[k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_table_q <= '0;
			enable_q     <= '0;
			thresh_q     <= '0;
			pend_q       <= '0;
			insvc_q      <= '0;
		end else begin
			pend_q  <= pend_d;
			insvc_q <= insvc_d;
			if (cfg_we) begin
				case (cfg_index)
					pic_pkg::REG_PRIORITY: begin
						prio_table_q <= cfg_data[pic_pkg::PRIO_TABLE_W-1:0];
					end
					pic_pkg::REG_ENABLE: begin
						enable_q <= cfg_data[pic_pkg::ENABLE_W-1:0];
					end
					pic_pkg::REG_THRESHOLD: begin
						thresh_q <= cfg_data[pic_pkg::PRIO_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			type_q      <= in_type;
			ignored_q   <= (in_type == pic_pkg::REQ_COMPLETE) && !comp_hit;
			pos_q       <= '0;
			best_id_q   <= '0;
			best_prio_q <= '0;
			have_one_q  <= 1'b0;
			have_two_q  <= 1'b0;
		end else if (cmd.scan_step) begin
			pos_q <= pos_q + 1'b1;
			if (cur_elig) begin
				have_one_q <= 1'b1;
				if (have_one_q) begin
					have_two_q <= 1'b1;
				end
				if (cur_prio > best_prio_q) begin
					best_prio_q <= cur_prio;
					best_id_q   <= pos_q + 1'b1;
				end
			end
		end
		if (cmd.load) begin
			if (type_q == pic_pkg::REQ_CLAIM) begin
				claimed_id <= best_id_q;
				irq_line   <= have_two_q;
			end else begin
				claimed_id <= '0;
				irq_line   <= have_one_q;
			end
			complete_ignored <= ignored_q;
		end
	end

	assign status.scan_last = (pos_q == pic_pkg::SRC_W'(NUM_SOURCES - 1));

endmodule

### src/platform_interrupt_controller.sv
// An input transfer starts a serial scan of the sources, and the result is registered once the scan ends.
// No new item is taken during the scan, which visits one source per cycle, or while the result waits to load.
// A new item is taken while the previous result still waits for its transfer.
// Reset clears all configuration registers and the pending and in-service bits.
// Depends on pic_pkg, pic_ctrl and pic_datapath.
module platform_interrupt_controller #(
	parameter int NUM_SOURCES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pic_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pic_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pic_pkg::IN_TDATA_W-1:0]     s_tdata,   // req_type[1:0], source_id[6:2]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pic_pkg::OUT_TDATA_W-1:0]    m_tdata    // claimed_id[4:0], irq_line[5], complete_ignored[6]
);

	pic_pkg::cmd_t              cmd;
	pic_pkg::status_t           status;
	logic [pic_pkg::SRC_W-1:0]  claimed_id;
	logic                       irq_line;
	logic                       complete_ignored;

	pic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	pic_datapath #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_type          (s_tdata[pic_pkg::REQ_W-1:0]),
		.in_sid           (s_tdata[pic_pkg::REQ_W +: pic_pkg::SRC_W]),
		.cmd              (cmd),
		.status           (status),
		.claimed_id       (claimed_id),
		.irq_line         (irq_line),
		.complete_ignored (complete_ignored)
	);

	assign m_tdata = {1'b0, complete_ignored, irq_line, claimed_id};

endmodule

### src/pic_monitor.sv
// Port-level checks for the platform interrupt controller, bound to its top level.
// Depends on pic_pkg and platform_interrupt_controller_macros.svh.
`include "platform_interrupt_controller_macros.svh"

module pic_monitor #(
	parameter int NUM_SOURCES = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [pic_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pic_pkg::OUT_TDATA_W-1:0] m_tdata
);

	`PIC_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid)
	`PIC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`PIC_ASSERT_SAME(a_claim_in_range, m_tvalid, m_tdata[4:0] <= pic_pkg::SRC_W'(NUM_SOURCES))
	`PIC_ASSERT_SAME(a_claim_not_ignored, m_tvalid, !(m_tdata[6] && (m_tdata[4:0] != 5'd0)))

endmodule

bind platform_interrupt_controller pic_monitor #(
	.NUM_SOURCES (NUM_SOURCES)
) u_monitor (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### sim/tb_platform_interrupt_controller.sv
// Self-checking testbench for platform_interrupt_controller: a stimulus table, then random traffic.
// Results are checked against an arbiter model kept in this file.
// Depends on pic_pkg and the controller RTL.
module tb_platform_interrupt_controller;

	localparam int N_SRC      = 16;
	localparam int N_RANDOM   = 750;
	localparam int QUIET_FROM = 650;
	localparam int PAUSE      = 4;
	localparam int TAIL       = 40;
	localparam int LIMIT_TIME = 2_000_000;

	localparam logic [pic_pkg::REQ_W-1:0]     REQ_UNUSED = 2'd3;
	localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

	typedef struct packed {
		logic [pic_pkg::SRC_W-1:0] claimed;
		logic                      irq;
		logic                      ignored;
	} outcome_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [1:0]                      op;
		logic [pic_pkg::CFG_DATA_W-1:0]  arg;
		logic                            typed;
		outcome_t                        outcome;
	} step_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pic_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [pic_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [pic_pkg::IN_TDATA_W-1:0]  s_tdata;   // req_type[1:0], source_id[6:2]
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [pic_pkg::OUT_TDATA_W-1:0] m_tdata;   // claimed_id[4:0], irq_line[5], complete_ignored[6]

	// Arbiter model state.
	logic [pic_pkg::PRIO_TABLE_W-1:0] prio_tbl;
	logic [pic_pkg::ENABLE_W-1:0]     en_mask;
	logic [pic_pkg::PRIO_W-1:0]       thr_lvl;
	logic [N_SRC-1:0]                 pend;
	logic [N_SRC-1:0]                 insvc;

	outcome_t results_due[$];
	outcome_t want;
	step_t    plan[$];

	bit quiet    = 1'b0;
	bit stall_on = 1'b0;
	bit gaps_on  = 1'b0;
	int stall_left = 0;
	int n_bad = 0, n_checked = 0, n_granted = 0, n_ignored = 0;
	int n_sent = 0, n_directed = 0, n_settings = 0;

	platform_interrupt_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic logic [pic_pkg::SRC_W-1:0] top_source();
		logic [pic_pkg::SRC_W-1:0]  best;
		logic [pic_pkg::PRIO_W-1:0] best_p;
		logic [pic_pkg::PRIO_W-1:0] p;
		best = '0;
		best_p = '0;
		for (int s = 1; s <= N_SRC; s++) begin
			p = prio_tbl[3*(s-1) +: 3];
			if (pend[s-1] && en_mask[s-1] && p > thr_lvl && p > best_p) begin
				best = pic_pkg::SRC_W'(s);
				best_p = p;
			end
		end
		return best;
	endfunction

	function automatic outcome_t arbitrate(input logic [1:0] op,
			input logic [pic_pkg::SRC_W-1:0] sid);
		outcome_t                  o;
		logic [pic_pkg::SRC_W-1:0] g;
		o = '0;
		case (op)
			pic_pkg::REQ_RAISE: begin
				if (sid >= 1 && sid <= N_SRC && !insvc[sid-1])
					pend[sid-1] = 1'b1;
			end
			pic_pkg::REQ_CLAIM: begin
				g = top_source();
				o.claimed = g;
				if (g != 0) begin
					pend[g-1] = 1'b0;
					insvc[g-1] = 1'b1;
				end
			end
			pic_pkg::REQ_COMPLETE: begin
				if (sid >= 1 && sid <= N_SRC && en_mask[sid-1])
					insvc[sid-1] = 1'b0;
				else
					o.ignored = 1'b1;
			end
			default: ;
		endcase
		o.irq = (top_source() != 0);
		return o;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer, valid still high.
	task automatic send_item(input logic [1:0] op, input logic [pic_pkg::SRC_W-1:0] sid,
			input logic typed, input outcome_t given);
		outcome_t o;
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, sid, op};
		do @(posedge clk); while (!s_tready);
		o = arbitrate(op, sid);
		if (typed)
			o = given;
		results_due.push_back(o);
		n_sent++;
		@(negedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it once the writes are done.
	task automatic write_reg(input logic [pic_pkg::CFG_IDX_W-1:0] idx,
			input logic [pic_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			pic_pkg::REG_PRIORITY:  prio_tbl = val;
			pic_pkg::REG_ENABLE:    en_mask = val[pic_pkg::ENABLE_W-1:0];
			pic_pkg::REG_THRESHOLD: thr_lvl = val[pic_pkg::PRIO_W-1:0];
			default: ;
		endcase
		n_settings++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (PAUSE) @(negedge clk);
	endtask

	task automatic next_random(output logic [1:0] op, output logic [pic_pkg::SRC_W-1:0] sid);
		int r;
		int k;
		r = int'($urandom_range(0, 99));
		sid = pic_pkg::SRC_W'($urandom_range(0, 31));
		if (r < 40) begin
			op = pic_pkg::REQ_RAISE;
			if ($urandom_range(0, 9) != 0)
				sid = pic_pkg::SRC_W'($urandom_range(1, N_SRC));
		end else if (r < 65) begin
			op = pic_pkg::REQ_CLAIM;
		end else if (r < 93) begin
			op = pic_pkg::REQ_COMPLETE;
			if (insvc != 0 && $urandom_range(0, 3) != 0) begin
				do k = int'($urandom_range(0, N_SRC - 1)); while (!insvc[k]);
				sid = pic_pkg::SRC_W'(k + 1);
			end else if ($urandom_range(0, 1) != 0) begin
				sid = pic_pkg::SRC_W'($urandom_range(1, N_SRC));
			end
		end else begin
			op = REQ_UNUSED;
		end
	endtask

	task automatic random_settings();
		logic [pic_pkg::CFG_DATA_W-1:0] v;
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 5))
				0: v = 48'hFFFF_FFFF_FFFF;
				1: v = 48'h2492_4924_9249;
				2: v = '0;
				default: begin
					v[47:32] = 16'($urandom_range(0, 16'hFFFF));
					v[31:0] = $urandom();
				end
			endcase
			write_reg(pic_pkg::REG_PRIORITY, v);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 4))
				0: v = 48'hFFFF;
				1: v = '0;
				2: v = 48'h1 << $urandom_range(0, 15);
				default: v = 48'($urandom_range(0, 16'hFFFF) | $urandom_range(0, 16'hFFFF));
			endcase
			write_reg(pic_pkg::REG_ENABLE, v);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 3))
				0: v = 48'd0;
				1: v = 48'd7;
				default: v = 48'($urandom_range(0, 6));
			endcase
			write_reg(pic_pkg::REG_THRESHOLD, v);
		end
		if ($urandom_range(0, 5) == 0) begin
			v[47:32] = 16'($urandom_range(0, 16'hFFFF));
			v[31:0] = $urandom();
			write_reg(REG_SPARE, v);
		end
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (!quiet && stall_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = int'($urandom_range(0, 7));
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$error("result transfer with no item outstanding: m_tdata=%h", m_tdata);
				n_bad++;
			end else begin
				want = results_due.pop_front();
				n_checked++;
				if (want.claimed != 0)
					n_granted++;
				if (want.ignored)
					n_ignored++;
				if (m_tdata[4:0] !== want.claimed) begin
					$error("claimed_id: expected %0d, got %0d", want.claimed, m_tdata[4:0]);
					n_bad++;
				end
				if (m_tdata[5] !== want.irq) begin
					$error("irq_line: expected %0d, got %0d", want.irq, m_tdata[5]);
					n_bad++;
				end
				if (m_tdata[6] !== want.ignored) begin
					$error("complete_ignored: expected %0d, got %0d", want.ignored, m_tdata[6]);
					n_bad++;
				end
			end
		end
	end

	initial begin
		#(LIMIT_TIME);
		$display("Timed out with %0d results outstanding", results_due.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [1:0]                op;
		logic [pic_pkg::SRC_W-1:0] sid;
		int                        n_rand;
		int                        burst;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		prio_tbl = '0;
		en_mask = '0;
		thr_lvl = '0;
		pend = '0;
		insvc = '0;
		n_rand = 0;

		// Straight after reset nothing is configured, so every outcome is known.
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd0,  1'b1, '{5'd0, 1'b0, 1'b0}});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_COMPLETE, 48'd0,  1'b1, '{5'd0, 1'b0, 1'b1}});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_COMPLETE, 48'd31, 1'b1, '{5'd0, 1'b0, 1'b1}});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd1,  1'b1, '{5'd0, 1'b0, 1'b0}});
		plan.push_back('{ROW_ITEM, REQ_UNUSED,            48'd31, 1'b1, '{5'd0, 1'b0, 1'b0}});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_PRIORITY, 48'hFFFF_FFFF_FFFF, 1'b0, '0});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_ENABLE,   48'hFFFF, 1'b0, '0});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_THRESHOLD, 48'd0, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd16, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd0,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd1,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd16, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd31, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd0,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_COMPLETE, 48'd1,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_COMPLETE, 48'd1,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd1,  1'b0, '0});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_THRESHOLD, 48'd7, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd2,  1'b1, '{5'd0, 1'b0, 1'b0}});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd0,  1'b1, '{5'd0, 1'b0, 1'b0}});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_PRIORITY, 48'h0000_0000_01C1, 1'b0, '0});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_THRESHOLD, 48'd6, 1'b0, '0});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_ENABLE,   48'h0000, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_COMPLETE, 48'd16, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd0,  1'b0, '0});
		plan.push_back('{ROW_CFG,  pic_pkg::REG_ENABLE,   48'hFFFF, 1'b0, '0});
		plan.push_back('{ROW_CFG,  REG_SPARE,             48'hFFFF_FFFF_FFFF, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd0,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_CLAIM,    48'd0,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_COMPLETE, 48'd16, 1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd0,  1'b0, '0});
		plan.push_back('{ROW_ITEM, pic_pkg::REQ_RAISE,    48'd17, 1'b0, '0});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (!cfg_we)
					settle();
				write_reg(plan[i].op, plan[i].arg);
			end else begin
				cfg_we <= 1'b0;
				send_item(plan[i].op, plan[i].arg[pic_pkg::SRC_W-1:0], plan[i].typed,
					plan[i].outcome);
			end
		end
		n_directed = n_sent;

		while (n_rand < N_RANDOM) begin
			settle();
			random_settings();
			cfg_we <= 1'b0;
			case ($urandom_range(0, 3))
				0: begin gaps_on = 1'b0; stall_on = 1'b0; end
				1: begin gaps_on = 1'b1; stall_on = 1'b0; end
				2: begin gaps_on = 1'b0; stall_on = 1'b1; end
				default: begin gaps_on = 1'b1; stall_on = 1'b1; end
			endcase
			burst = int'($urandom_range(15, 50));
			for (int j = 0; j < burst && n_rand < N_RANDOM; j++) begin
				if (n_rand >= QUIET_FROM)
					quiet = 1'b1;
				next_random(op, sid);
				send_item(op, sid, 1'b0, '0);
				n_rand++;
				if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(negedge clk);
				end
			end
		end

		settle();
		repeat (TAIL) @(posedge clk);
		$display("Sent %0d items (%0d from the table) over %0d register writes.",
			n_sent, n_directed, n_settings);
		$display("Checked %0d results: %0d claims granted, %0d completions ignored.",
			n_checked, n_granted, n_ignored);
		if (n_bad == 0 && results_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
